// ===== design/usb_setup_request_decoder_defines.svh =====
// assertion macros for the usb setup request decoder
// expects signals named clk and rst_n in the scope where a macro is used
`ifndef USB_SETUP_REQUEST_DECODER_DEFINES_SVH
`define USB_SETUP_REQUEST_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// consequent checked in the same cycle
`define USRD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("usrd: same-cycle check failed");
// consequent checked in the cycle after the antecedent
`define USRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("usrd: next-cycle check failed");
`else
`define USRD_ASSERT_SAME(label, ante, cons)
`define USRD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/usrd_pkg.sv =====
// shared types, request keys and constants of the usb setup request decoder
// no dependencies
package usrd_pkg;

  // descriptor length registers
  localparam int NUM_REGS  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int DLEN_W    = 8;

  typedef logic [CFG_IDX_W-1:0]              cfg_idx_t;
  typedef logic [NUM_REGS-1:0][DLEN_W-1:0]   desc_len_t;

  localparam cfg_idx_t REG_DEVICE_DESC = 3'd0;
  localparam cfg_idx_t REG_LANG_STRING = 3'd1;
  localparam cfg_idx_t REG_COUNT       = cfg_idx_t'(NUM_REGS);

  // reset byte counts, index 0 on the right
  localparam desc_len_t DESC_LEN_RESET = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd4, 8'd18};

  // response kinds
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_STALL  = 2'd1,
    ACT_SEND   = 2'd2,
    ACT_EXPECT = 2'd3
  } act_t;

  // data sources for the in data stage
  typedef logic [3:0] src_t;
  localparam src_t SRC_ZERO_PAIR     = 4'd0;
  localparam src_t SRC_DEVICE_DESC   = 4'd1;
  localparam src_t SRC_CONFIG_DESC   = 4'd2;
  localparam src_t SRC_STRING_BASE   = 4'd3;
  localparam src_t SRC_CONFIGURATION = 4'd9;
  localparam src_t SRC_INTERFACE     = 4'd10;
  localparam src_t SRC_LINE_CODING   = 4'd11;

  // request keys: bmRequestType in the high byte, bRequest in the low byte
  typedef logic [15:0] key_t;
  localparam key_t KEY_GET_STATUS_DEV        = 16'h8000;
  localparam key_t KEY_GET_STATUS_IF         = 16'h8100;
  localparam key_t KEY_GET_STATUS_EP         = 16'h8200;
  localparam key_t KEY_IN_CONFIG_LONG        = 16'h8002;
  localparam key_t KEY_GET_DESCRIPTOR        = 16'h8006;
  localparam key_t KEY_GET_CONFIGURATION     = 16'h8008;
  localparam key_t KEY_GET_INTERFACE         = 16'h810A;
  localparam key_t KEY_OUT_STATUS            = 16'h0000;
  localparam key_t KEY_CLEAR_FEATURE         = 16'h0001;
  localparam key_t KEY_SET_FEATURE           = 16'h0003;
  localparam key_t KEY_ASSIGN_BUS_ADDR       = 16'h0005;
  localparam key_t KEY_OUT_GET_DESCRIPTOR    = 16'h0006;
  localparam key_t KEY_SET_DESCRIPTOR        = 16'h0007;
  localparam key_t KEY_OUT_GET_CONFIGURATION = 16'h0008;
  localparam key_t KEY_SET_CONFIGURATION     = 16'h0009;
  localparam key_t KEY_OUT_GET_INTERFACE     = 16'h000A;
  localparam key_t KEY_SET_INTERFACE        = 16'h000B;
  localparam key_t KEY_SYNCH_FRAME           = 16'h000C;
  localparam key_t KEY_CLASS_NOP_A           = 16'h2100;
  localparam key_t KEY_CLASS_NOP_B           = 16'h2101;
  localparam key_t KEY_SEND_ENCAPSULATED     = 16'h2120;
  localparam key_t KEY_GET_LINE_CODING       = 16'h2121;
  localparam key_t KEY_SET_CONTROL_LINE_ST   = 16'h2122;

  // descriptor types
  localparam logic [7:0] DT_DEVICE      = 8'd1;
  localparam logic [7:0] DT_CONFIG      = 8'd2;
  localparam logic [7:0] DT_STRING      = 8'd3;
  localparam logic [7:0] DT_INTERFACE   = 8'd4;
  localparam logic [7:0] DT_ENDPOINT    = 8'd5;
  localparam logic [7:0] DT_QUALIFIER   = 8'd6;
  localparam logic [7:0] DT_OTHER_SPEED = 8'd7;

  localparam logic [7:0] STRING_MAX_IDX    = 8'd5;
  localparam logic [7:0] DESC_STALL_MAX_IDX = 8'd1;

  // fixed byte counts
  localparam logic [15:0] LEN_STATUS      = 16'd2;
  localparam logic [15:0] LEN_ONE         = 16'd1;
  localparam logic [15:0] LEN_LINE_CODING = 16'd7;

  localparam int ADDR_W = 7;

  // one setup event
  typedef struct packed {
    logic        func;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [7:0]  value_low;
    logic [7:0]  value_high;
    logic [15:0] index_value;
    logic [15:0] length_value;
  } req_t;

  // answer for the data stage
  typedef struct packed {
    act_t        act;
    src_t        src;
    logic [15:0] len;
  } answer_t;

  // state updates requested by the decoded request
  typedef struct packed {
    logic set_pending;
    logic set_config;
    logic set_iface;
    logic set_lines;
  } upd_t;

  function automatic answer_t reply(act_t a, src_t s, logic [15:0] n);
    answer_t r;
    r.act = a;
    r.src = s;
    r.len = n;
    return r;
  endfunction

endpackage

// ===== design/usrd_decode.sv =====
// combinational decode of one setup packet into an answer and state updates
// depends on usrd_pkg
module usrd_decode (
  input  usrd_pkg::req_t      req,
  input  usrd_pkg::desc_len_t desc_len,
  output usrd_pkg::answer_t   ans,
  output usrd_pkg::upd_t      upd
);
  import usrd_pkg::*;

  key_t            key;
  logic            str_ok;
  cfg_idx_t        str_reg;
  answer_t         str_ans;
  answer_t         none_ans;
  answer_t         stall_ans;
  logic [15:0]     dev_len;

  assign key       = {req.request_type, req.request_code};
  assign none_ans  = reply(ACT_NONE, SRC_ZERO_PAIR, 16'd0);
  assign stall_ans = reply(ACT_STALL, SRC_ZERO_PAIR, 16'd0);
  assign dev_len   = {8'd0, desc_len[REG_DEVICE_DESC]};

  // string descriptor lookup, indexes above five get no answer
  assign str_ok  = (req.value_low <= STRING_MAX_IDX);
  assign str_reg = cfg_idx_t'(req.value_low[CFG_IDX_W-1:0] + REG_LANG_STRING);
  always_comb begin
    str_ans = none_ans;
    if (str_ok) begin
      str_ans = reply(ACT_SEND, src_t'(SRC_STRING_BASE + req.value_low[3:0]),
                      {8'd0, desc_len[str_reg]});
    end
  end

  // request decode
  always_comb begin
    ans = none_ans;
    upd = '0;
    if (req.func) begin
      unique case (key) inside
        KEY_GET_STATUS_DEV, KEY_GET_STATUS_IF, KEY_GET_STATUS_EP, KEY_OUT_STATUS: begin
          ans = reply(ACT_SEND, SRC_ZERO_PAIR, LEN_STATUS);
        end
        KEY_IN_CONFIG_LONG: begin
          ans = reply(ACT_SEND, SRC_CONFIGURATION, req.length_value);
        end
        KEY_GET_DESCRIPTOR: begin
          unique case (req.value_high) inside
            DT_DEVICE: ans = reply(ACT_SEND, SRC_DEVICE_DESC, dev_len);
            DT_CONFIG: ans = reply(ACT_SEND, SRC_CONFIG_DESC, req.length_value);
            DT_STRING: ans = str_ans;
            DT_INTERFACE, DT_ENDPOINT: begin
              if (req.value_low <= DESC_STALL_MAX_IDX) begin
                ans = stall_ans;
              end
            end
            DT_QUALIFIER, DT_OTHER_SPEED: ans = none_ans;
            default: ans = stall_ans;
          endcase
        end
        KEY_OUT_GET_DESCRIPTOR: begin
          unique case (req.value_high) inside
            DT_DEVICE: ans = reply(ACT_SEND, SRC_DEVICE_DESC, dev_len);
            DT_STRING: ans = str_ans;
            default:   ans = stall_ans;
          endcase
        end
        KEY_GET_CONFIGURATION, KEY_OUT_GET_CONFIGURATION: begin
          ans = reply(ACT_SEND, SRC_CONFIGURATION, LEN_ONE);
        end
        KEY_GET_INTERFACE, KEY_OUT_GET_INTERFACE: begin
          ans = reply(ACT_SEND, SRC_INTERFACE, LEN_ONE);
        end
        KEY_CLEAR_FEATURE, KEY_SET_FEATURE, KEY_CLASS_NOP_A, KEY_CLASS_NOP_B: begin
          ans = none_ans;
        end
        KEY_ASSIGN_BUS_ADDR:     upd.set_pending = 1'b1;
        KEY_SET_CONFIGURATION:   upd.set_config  = 1'b1;
        KEY_SET_INTERFACE:       upd.set_iface   = 1'b1;
        KEY_SET_CONTROL_LINE_ST: upd.set_lines   = 1'b1;
        KEY_SEND_ENCAPSULATED: begin
          ans = reply(ACT_EXPECT, SRC_ZERO_PAIR, req.length_value);
        end
        KEY_GET_LINE_CODING: begin
          ans = reply(ACT_SEND, SRC_LINE_CODING, LEN_LINE_CODING);
        end
        KEY_SET_DESCRIPTOR, KEY_SYNCH_FRAME: ans = stall_ans;
        default: ans = stall_ans;
      endcase
    end
  end

endmodule

// ===== design/usb_setup_request_decoder.sv =====
// Endpoint-0 setup request decoder. Each accepted event first applies a pending
// bus address request (low 7 bits), then decodes a setup packet into none, stall, send
// (source and byte count) or expect-data, and records address, configuration,
// interface and control line state. One event is accepted every cycle while no
// result is held or the consumer takes the held result in the same cycle; its
// result appears in the next cycle from the output register. The user must write
// descriptor byte counts through the cfg port only while idle; the block does not check.
// depends on usrd_pkg, usrd_decode and usb_setup_request_decoder_defines.svh
`include "usb_setup_request_decoder_defines.svh"

module usb_setup_request_decoder (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_func,
  input  logic [7:0]                in_request_type,
  input  logic [7:0]                in_request_code,
  input  logic [7:0]                in_value_low,
  input  logic [7:0]                in_value_high,
  input  logic [15:0]               in_index_value,
  input  logic [15:0]               in_length_value,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_action,
  output logic [3:0]                out_data_source,
  output logic [15:0]               out_send_length,
  output logic [6:0]                out_device_address,
  output logic [7:0]                out_configuration_value,
  output logic [7:0]                out_interface_value,
  output logic [15:0]               out_control_lines,
  output logic                      out_address_pending,
  // configuration port
  input  logic                      cfg_wr_en,
  input  usrd_pkg::cfg_idx_t        cfg_index,
  input  logic [usrd_pkg::DLEN_W-1:0] cfg_wdata
);
  import usrd_pkg::*;

  logic              accept;
  req_t              req;
  answer_t           ans;
  upd_t              upd;

  desc_len_t         desc_len_r;
  logic              out_valid_r, out_valid_nxt;
  answer_t           ans_r;
  logic [ADDR_W-1:0] applied_r, applied_nxt;
  logic              pending_r, pending_nxt;
  logic [7:0]        pend_addr_r, pend_addr_nxt;
  logic [7:0]        config_r, config_nxt;
  logic [7:0]        iface_r, iface_nxt;
  logic [15:0]       lines_r, lines_nxt;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;

  assign req.func         = in_func;
  assign req.request_type = in_request_type;
  assign req.request_code = in_request_code;
  assign req.value_low    = in_value_low;
  assign req.value_high   = in_value_high;
  assign req.index_value  = in_index_value;
  assign req.length_value = in_length_value;

  usrd_decode u_decode (
    .req      (req),
    .desc_len (desc_len_r),
    .ans      (ans),
    .upd      (upd)
  );

  // descriptor length registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_len_r <= DESC_LEN_RESET;
    end else if (cfg_wr_en && (cfg_index < REG_COUNT)) begin
      desc_len_r[cfg_index] <= cfg_wdata;
    end
  end

  // next state: apply a pending address, then record the request
  always_comb begin
    applied_nxt   = pending_r ? pend_addr_r[ADDR_W-1:0] : applied_r;
    pending_nxt   = upd.set_pending;
    pend_addr_nxt = upd.set_pending ? in_value_low : pend_addr_r;
    config_nxt    = upd.set_config ? in_value_low : config_r;
    iface_nxt     = upd.set_iface ? in_index_value[7:0] : iface_r;
    lines_nxt     = upd.set_lines ? {in_value_high, in_value_low} : lines_r;
  end

  // output valid: set on transfer in, cleared on transfer out
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control and recorded state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      applied_r   <= '0;
      pending_r   <= 1'b0;
      pend_addr_r <= '0;
      config_r    <= '0;
      iface_r     <= '0;
      lines_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        applied_r   <= applied_nxt;
        pending_r   <= pending_nxt;
        pend_addr_r <= pend_addr_nxt;
        config_r    <= config_nxt;
        iface_r     <= iface_nxt;
        lines_r     <= lines_nxt;
      end
    end
  end

  // answer payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      ans_r <= ans;
    end
  end

  // result ports; recorded state only moves on an input transfer
  assign out_valid               = out_valid_r;
  assign out_action              = ans_r.act;
  assign out_data_source         = ans_r.src;
  assign out_send_length         = ans_r.len;
  assign out_device_address      = applied_r;
  assign out_configuration_value = config_r;
  assign out_interface_value     = iface_r;
  assign out_control_lines       = lines_r;
  assign out_address_pending     = pending_r;

  // checks
  `USRD_ASSERT_NEXT(a_pending_applied, accept && pending_r, applied_r == $past(pend_addr_r[ADDR_W-1:0]))
  `USRD_ASSERT_NEXT(a_pending_only_addr_req, accept && !upd.set_pending, !pending_r)
  `USRD_ASSERT_SAME(a_quiet_fields_zero, out_valid_r && (ans_r.act == ACT_NONE || ans_r.act == ACT_STALL), ans_r.src == SRC_ZERO_PAIR && ans_r.len == 16'd0)
  `USRD_ASSERT_SAME(a_expect_no_source, out_valid_r && ans_r.act == ACT_EXPECT, ans_r.src == SRC_ZERO_PAIR)
  `USRD_ASSERT_NEXT(a_state_holds_idle, !accept, $stable(applied_r) && $stable(pending_r) && $stable(config_r) && $stable(iface_r) && $stable(lines_r))

endmodule
